### src/hls_pkg.sv
// hls_pkg: shared types and constants for the lightness shift pipeline.
// No dependencies.
package hls_pkg;

  localparam int unsigned ChanMax = 255;
  localparam int unsigned DeltaInBits = 16;
  localparam int unsigned DeltaMax = 65536;

  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } sector_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [16:0] shift_amt;
  } pix_req_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } pix_res_t;

endpackage

### src/hls_stream_if.sv
// hls_stream_if: valid/ready channel carrying a payload of type PAYLOAD_T.
// No dependencies; the payload type is given as a parameter.
interface hls_stream_if #(
  parameter type PAYLOAD_T = logic
);
  logic     valid;
  logic     ready;
  PAYLOAD_T data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/hls_rdiv.sv
// hls_rdiv: pipelined restoring divider, one quotient bit per stage, round to nearest.
// q = (a + b/2) / b, zero when b is zero. Moves only when en_i is high.
module hls_rdiv #(
  parameter int unsigned AW = 26,
  parameter int unsigned BW = 9,
  parameter int unsigned QW = 18
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [AW-1:0] a_i,
  input  logic [BW-1:0] b_i,
  output logic [QW-1:0] q_o
);
  localparam int unsigned RW = BW + 1;

  logic [AW:0]   num_q  [QW+1];
  logic [BW-1:0] den_q  [QW+1];
  logic [RW-1:0] rem_q  [QW+1];
  logic [QW-1:0] quo_q  [QW+1];
  logic          zero_q [QW+1];

  logic [AW:0] num_d;
  assign num_d = {1'b0, a_i} + (AW+1)'(b_i >> 1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q[0]  <= num_d;
      den_q[0]  <= b_i;
      rem_q[0]  <= RW'(num_d >> QW);
      quo_q[0]  <= '0;
      zero_q[0] <= (b_i == '0);
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int unsigned Bit = QW - 1 - s;
    logic [RW:0] trial;
    logic        nb;
    always_comb begin
      nb    = (Bit <= AW) ? num_q[s][Bit] : 1'b0;
      trial = {rem_q[s], nb};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s+1]  <= num_q[s];
        den_q[s+1]  <= den_q[s];
        zero_q[s+1] <= zero_q[s];
        if (trial >= {2'b0, den_q[s]}) begin
          rem_q[s+1] <= RW'(trial - {2'b0, den_q[s]});
          quo_q[s+1] <= quo_q[s] | (QW'(1) << Bit);
        end else begin
          rem_q[s+1] <= RW'(trial);
          quo_q[s+1] <= quo_q[s];
        end
      end
    end
  end

  assign q_o = zero_q[QW] ? '0 : quo_q[QW];
endmodule

### src/hsl_lightness_shift.sv
// hsl_lightness_shift: RGB to HSL lightness shift and back, fully pipelined.
// Depends on hls_pkg, hls_stream_if and hls_rdiv.
//
// Takes one pixel per clock and returns one pixel per clock while the
// output is not stalled. A request passes the input stage, the
// bit-per-stage dividers for saturation and hue fraction, and seven
// arithmetic stages. Lightness uses a constant reciprocal multiply
// carried alongside the dividers. The whole pipeline advances together
// and halts while a result waits at the output, so nothing is lost or
// repeated under back-pressure.
module hsl_lightness_shift #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  hls_stream_if.sink   in_i,
  hls_stream_if.source out_o
);
  localparam int unsigned FW  = FRAC_BITS + 1;
  localparam logic [FW-1:0] One = FW'(1) << FRAC_BITS;
  localparam int unsigned AW  = FRAC_BITS + 10;
  localparam int unsigned DL  = FRAC_BITS + 2;
  localparam int unsigned NS  = DL + 9;
  localparam int unsigned LumSh = 20;
  localparam int unsigned KW  = FRAC_BITS + 12;
  localparam int unsigned MW  = FRAC_BITS + 21;
  localparam logic [KW-1:0] LumK = KW'((64'd1 << (FRAC_BITS + LumSh - 1)) / 64'd255);

  logic en;
  logic [NS-1:0] vld_q;
  assign en       = ~vld_q[NS-1] | out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], in_i.valid};
    end
  end

  // stage 0: delta, max/min, hue numerator
  logic [7:0] r, g, b;
  logic [16:0] dq;
  assign r  = in_i.data.red_in;
  assign g  = in_i.data.green_in;
  assign b  = in_i.data.blue_in;
  assign dq = in_i.data.shift_amt;

  logic [FW-1:0] del_d;
  logic [7:0] mx, mn;
  logic [2:0] base;
  logic       neg;
  logic [7:0] mag;
  always_comb begin
    logic [16:0] dc;
    logic [17:0] tmp;
    tmp = '0;
    dc = (dq > 17'(hls_pkg::DeltaMax)) ? 17'(hls_pkg::DeltaMax) : dq;
    if (FRAC_BITS >= hls_pkg::DeltaInBits) begin
      del_d = FW'(dc) << (FRAC_BITS - hls_pkg::DeltaInBits);
    end else begin
      tmp   = 18'(dc) + (18'(1) << (hls_pkg::DeltaInBits - FRAC_BITS - 1));
      del_d = FW'(tmp >> (hls_pkg::DeltaInBits - FRAC_BITS));
    end
    mx = (r > g) ? r : g;
    mx = (mx > b) ? mx : b;
    mn = (r < g) ? r : g;
    mn = (mn < b) ? mn : b;
    if (mx == r) begin
      base = 3'd0; neg = g < b; mag = neg ? b - g : g - b;
    end else if (mx == g) begin
      base = 3'd2; neg = b < r; mag = neg ? r - b : b - r;
    end else begin
      base = 3'd4; neg = r < g; mag = neg ? g - r : r - g;
    end
  end

  logic [FW-1:0] del_q;
  logic [8:0]    sum_q;
  logic [7:0]    c8_q, mag_q;
  logic [2:0]    base_q;
  logic          neg_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      del_q  <= del_d;
      sum_q  <= 9'(mx) + 9'(mn);
      c8_q   <= mx - mn;
      mag_q  <= mag;
      base_q <= base;
      neg_q  <= neg;
    end
  end

  // stage 1: dividers; lightness is sum/510 by reciprocal multiply
  logic [8:0] sden;
  assign sden = (sum_q <= 9'(hls_pkg::ChanMax)) ? sum_q : 9'(2*hls_pkg::ChanMax) - sum_q;

  logic [MW-1:0] lum_m;
  logic [FW-1:0] lum_d;
  assign lum_m = MW'(sum_q) * LumK + (MW'(1) << (LumSh - 1));
  assign lum_d = FW'(lum_m >> LumSh);

  logic [DL-1:0] sat_w, hq_w;
  hls_rdiv #(.AW(AW), .BW(9), .QW(DL)) u_sat (
    .clk_i, .en_i(en), .a_i(AW'(c8_q) << FRAC_BITS),
    .b_i(c8_q == '0 ? 9'd0 : sden), .q_o(sat_w));
  hls_rdiv #(.AW(AW), .BW(9), .QW(DL)) u_hue (
    .clk_i, .en_i(en), .a_i(AW'(mag_q) << FRAC_BITS),
    .b_i(9'(c8_q)), .q_o(hq_w));

  logic [FW-1:0] dly_del [DL+1];
  logic [FW-1:0] dly_lum [DL+1];
  logic [2:0]    dly_base [DL+1];
  logic          dly_neg [DL+1];
  logic          dly_chr [DL+1];
  always_ff @(posedge clk_i) begin
    if (en) begin
      dly_del[0]  <= del_q;
      dly_lum[0]  <= lum_d;
      dly_base[0] <= base_q;
      dly_neg[0]  <= neg_q;
      dly_chr[0]  <= c8_q != '0;
      for (int i = 0; i < DL; i++) begin
        dly_del[i+1]  <= dly_del[i];
        dly_lum[i+1]  <= dly_lum[i];
        dly_base[i+1] <= dly_base[i];
        dly_neg[i+1]  <= dly_neg[i];
        dly_chr[i+1]  <= dly_chr[i];
      end
    end
  end

  // stage A: hue split, saturation clamp, lightness product
  logic [2:0]    sec_d;
  logic [FW-1:0] frac_d, sat_d, fact_d;
  logic [FW-1:0] lum;
  logic          dark_d;
  always_comb begin
    lum    = dly_lum[DL];
    sat_d  = '0;
    sec_d  = 3'd0;
    frac_d = '0;
    if (dly_chr[DL]) begin
      sat_d = (sat_w > DL'(One)) ? One : FW'(sat_w);
      if (!dly_neg[DL]) begin
        if (hq_w >= DL'(One)) begin
          sec_d = dly_base[DL] + 3'd1;
        end else begin
          sec_d = dly_base[DL]; frac_d = FW'(hq_w);
        end
      end else if (hq_w != '0) begin
        sec_d  = (dly_base[DL] == 3'd0) ? 3'd5 : dly_base[DL] - 3'd1;
        frac_d = One - ((hq_w > DL'(One)) ? One : FW'(hq_w));
      end
    end
    dark_d = ({1'b0, lum} << 1) <= (FW+1)'(One);
    fact_d = dark_d ? dly_del[DL] : One - dly_del[DL];
  end

  logic [FW-1:0]   a_lum_q, a_sat_q, a_frac_q;
  logic [2:0]      a_sec_q;
  logic            a_dark_q;
  logic [2*FW-1:0] a_prod_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_lum_q  <= lum;
      a_sat_q  <= sat_d;
      a_frac_q <= frac_d;
      a_sec_q  <= sec_d;
      a_dark_q <= dark_d;
      a_prod_q <= (dark_d ? One - lum : lum) * fact_d;
    end
  end

  // stage B: new lightness, span
  logic [FW-1:0] l2_d, span_d;
  always_comb begin
    logic [2*FW-1:0] rq;
    logic [FW:0]     t;
    rq = (a_prod_q + (2*FW)'(One >> 1)) >> FRAC_BITS;
    t  = a_dark_q ? (FW+1)'(a_lum_q) + (FW+1)'(rq) : (FW+1)'(rq);
    l2_d = (t > (FW+1)'(One)) ? One : FW'(t);
    span_d = (({1'b0, l2_d} << 1) >= (FW+1)'(One))
           ? FW'(((FW+1)'(One) << 1) - ({1'b0, l2_d} << 1))
           : FW'({1'b0, l2_d} << 1);
  end

  logic [FW-1:0] b_l2_q, b_sat_q, b_w_q;
  logic [FW:0]   b_span_q;
  logic [2:0]    b_sec_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      b_l2_q   <= l2_d;
      b_span_q <= {1'b0, span_d};
      b_sat_q  <= a_sat_q;
      b_sec_q  <= a_sec_q;
      b_w_q    <= a_sec_q[0] ? One - a_frac_q : a_frac_q;
    end
  end

  // stage C: chroma product
  logic [2*FW+1:0] c_prod_q;
  logic [FW-1:0]   c_l2_q, c_w_q;
  logic [2:0]      c_sec_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      c_prod_q <= (2*FW+2)'(b_span_q * b_sat_q);
      c_l2_q   <= b_l2_q;
      c_w_q    <= b_w_q;
      c_sec_q  <= b_sec_q;
    end
  end

  logic [FW:0] c2_d;
  assign c2_d = (FW+1)'((c_prod_q + (2*FW+2)'(One >> 1)) >> FRAC_BITS);

  logic [FW:0]   d_c2_q;
  logic [FW-1:0] d_l2_q, d_w_q;
  logic [2:0]    d_sec_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      d_c2_q  <= c2_d;
      d_l2_q  <= c_l2_q;
      d_w_q   <= c_w_q;
      d_sec_q <= c_sec_q;
    end
  end

  // stage E: secondary component product
  logic [2*FW:0] e_prod_q;
  logic [FW:0]   e_c2_q;
  logic [FW-1:0] e_l2_q;
  logic [2:0]    e_sec_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      e_prod_q <= (2*FW+1)'(d_c2_q * d_w_q);
      e_c2_q   <= d_c2_q;
      e_l2_q   <= d_l2_q;
      e_sec_q  <= d_sec_q;
    end
  end

  // stage F: assemble doubled channel values
  localparam int unsigned VW = FW + 3;
  logic [VW-1:0] vr_d, vg_d, vb_d;
  function automatic logic [VW-1:0] chan(input logic [FW:0] part,
                                         input logic [FW-1:0] l2,
                                         input logic [FW:0] c2);
    logic signed [VW+1:0] v;
    v = $signed({2'b0, VW'(part) << 1}) + $signed({2'b0, VW'(l2) << 1})
      - $signed({2'b0, VW'(c2)});
    if (v < 0) v = '0;
    if (v > $signed((VW+2)'(One) << 1)) v = $signed((VW+2)'(One) << 1);
    return VW'(v);
  endfunction

  always_comb begin
    logic [FW:0] x, pr, pg, pb;
    x  = (FW+1)'((e_prod_q + (2*FW+1)'(One >> 1)) >> FRAC_BITS);
    pr = '0; pg = '0; pb = '0;
    case (hls_pkg::sector_e'(e_sec_q))
      hls_pkg::SEC_0: begin pr = e_c2_q; pg = x; end
      hls_pkg::SEC_1: begin pr = x; pg = e_c2_q; end
      hls_pkg::SEC_2: begin pg = e_c2_q; pb = x; end
      hls_pkg::SEC_3: begin pg = x; pb = e_c2_q; end
      hls_pkg::SEC_4: begin pr = x; pb = e_c2_q; end
      default:        begin pr = e_c2_q; pb = x; end
    endcase
    vr_d = chan(pr, e_l2_q, e_c2_q);
    vg_d = chan(pg, e_l2_q, e_c2_q);
    vb_d = chan(pb, e_l2_q, e_c2_q);
  end

  logic [VW-1:0] f_r_q, f_g_q, f_b_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      f_r_q <= vr_d;
      f_g_q <= vg_d;
      f_b_q <= vb_d;
    end
  end

  // stage G: scale to 8 bits
  function automatic logic [7:0] scale(input logic [VW-1:0] v);
    logic [VW+8:0] m;
    m = (VW+9)'(v) * (VW+9)'(hls_pkg::ChanMax) + (VW+9)'(One);
    return 8'(m >> (FRAC_BITS + 1));
  endfunction

  hls_pkg::rgb_t res_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q.red   <= scale(f_r_q);
      res_q.green <= scale(f_g_q);
      res_q.blue  <= scale(f_b_q);
    end
  end

  assign out_o.valid          = vld_q[NS-1];
  assign out_o.data.red_out   = res_q.red;
  assign out_o.data.green_out = res_q.green;
  assign out_o.data.blue_out  = res_q.blue;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(res_q))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("input stalled with empty output");
  a_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> vld_q[0])
    else $error("accepted request lost");
endmodule

### tb/tb.sv
// tb: self-checking regression for hsl_lightness_shift, directed table then random pixels.
// Depends on hls_pkg, hls_stream_if and the hsl_lightness_shift RTL.
// Results per request come from a fixed-point model or a known table row; checked in order.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FracBits = 16;
  localparam longint unsigned One = 64'd1 << FracBits;
  localparam int unsigned NumRandom = 500;
  localparam int unsigned Latency = FracBits + 10;

  typedef struct {
    hls_pkg::rgb_t     rgb;
    logic [16:0]       delta;
    bit                known;
    hls_pkg::pix_res_t want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  hls_stream_if #(.PAYLOAD_T(hls_pkg::pix_req_t)) in_if ();
  hls_stream_if #(.PAYLOAD_T(hls_pkg::pix_res_t)) out_if ();

  hsl_lightness_shift #(.FRAC_BITS(FracBits)) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  hls_pkg::pix_req_t reqs[$];
  hls_pkg::pix_res_t shifted_q[$];
  hls_pkg::pix_res_t known_q[$];
  bit       is_known[$];
  int       n_mismatch = 0;
  int       n_accepted = 0;
  int       n_results = 0;
  int       n_grey = 0;
  bit       hold_off = 1'b0;
  bit       sending_done = 1'b0;

  function automatic longint unsigned rdiv(longint unsigned a, longint unsigned b);
    if (b == 0) return 0;
    return (a + b / 2) / b;
  endfunction

  function automatic logic [7:0] to_chan(longint unsigned part, longint unsigned l2,
                                         longint unsigned c2);
    longint v;
    longint unsigned u;
    v = longint'(2 * part) + longint'(2 * l2) - longint'(c2);
    if (v < 0) v = 0;
    u = longint'(v);
    if (u > 2 * One) u = 2 * One;
    return 8'((u * 255 + One) / (2 * One));
  endfunction

  function automatic hls_pkg::pix_res_t shift_lightness(hls_pkg::pix_req_t p);
    int unsigned r, g, b, mx, mn, sum, c8, dd, base, sh;
    int num;
    longint unsigned delta, lum, l2, sat, frac, span, c2, x, w, q, pr, pg, pb;
    hls_pkg::sector_e sec;
    hls_pkg::pix_res_t res;
    r = p.red_in; g = p.green_in; b = p.blue_in;
    delta = (p.shift_amt > hls_pkg::DeltaMax) ? hls_pkg::DeltaMax : p.shift_amt;
    if (FracBits >= hls_pkg::DeltaInBits) begin
      delta = delta << (FracBits - hls_pkg::DeltaInBits);
    end else begin
      sh = hls_pkg::DeltaInBits - FracBits;
      delta = (delta + (64'd1 << (sh - 1))) >> sh;
    end
    if (delta > One) delta = One;
    mx = (r > g) ? r : g; mx = (mx > b) ? mx : b;
    mn = (r < g) ? r : g; mn = (mn < b) ? mn : b;
    sum = mx + mn; c8 = mx - mn;
    lum = rdiv(longint'(sum) * One, 2 * hls_pkg::ChanMax);
    sat = 0; frac = 0; sec = hls_pkg::SEC_0;
    if (c8 > 0) begin
      dd = (sum <= hls_pkg::ChanMax) ? sum : 2 * hls_pkg::ChanMax - sum;
      sat = rdiv(longint'(c8) * One, dd);
      if (sat > One) sat = One;
      if (mx == r) begin base = 0; num = int'(g) - int'(b); end
      else if (mx == g) begin base = 2; num = int'(b) - int'(r); end
      else begin base = 4; num = int'(r) - int'(g); end
      if (num >= 0) begin
        q = rdiv(longint'(num) * One, c8);
        if (q >= One) begin sec = hls_pkg::sector_e'((base + 1) % 6); frac = 0; end
        else begin sec = hls_pkg::sector_e'(base); frac = q; end
      end else begin
        q = rdiv(longint'(-num) * One, c8);
        if (q == 0) begin sec = hls_pkg::sector_e'(base); frac = 0; end
        else begin
          sec = hls_pkg::sector_e'((base + 5) % 6);
          frac = One - ((q > One) ? One : q);
        end
      end
    end
    if (2 * lum <= One) l2 = lum + rdiv((One - lum) * delta, One);
    else l2 = rdiv(lum * (One - delta), One);
    if (l2 > One) l2 = One;
    span = (2 * l2 >= One) ? 2 * One - 2 * l2 : 2 * l2;
    c2 = rdiv(span * sat, One);
    w = sec[0] ? One - frac : frac;
    x = rdiv(c2 * w, One);
    pr = 0; pg = 0; pb = 0;
    case (sec)
      hls_pkg::SEC_0: begin pr = c2; pg = x; end
      hls_pkg::SEC_1: begin pr = x; pg = c2; end
      hls_pkg::SEC_2: begin pg = c2; pb = x; end
      hls_pkg::SEC_3: begin pg = x; pb = c2; end
      hls_pkg::SEC_4: begin pr = x; pb = c2; end
      default: begin pr = c2; pb = x; end
    endcase
    res.red_out = to_chan(pr, l2, c2);
    res.green_out = to_chan(pg, l2, c2);
    res.blue_out = to_chan(pb, l2, c2);
    return res;
  endfunction

  dir_row_t dir_tab[] = '{
    '{'{8'd0, 8'd0, 8'd0}, 17'd0, 1'b1, '{8'd0, 8'd0, 8'd0}},
    '{'{8'd255, 8'd255, 8'd255}, 17'd0, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{'{8'd0, 8'd0, 8'd0}, 17'd65536, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{'{8'd255, 8'd255, 8'd255}, 17'd65536, 1'b1, '{8'd0, 8'd0, 8'd0}},
    '{'{8'd0, 8'd0, 8'd0}, 17'h1ffff, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{'{8'd255, 8'd255, 8'd255}, 17'h1ffff, 1'b1, '{8'd0, 8'd0, 8'd0}},
    '{'{8'd128, 8'd128, 8'd128}, 17'd0, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{'{8'd127, 8'd127, 8'd127}, 17'd32768, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{'{8'd255, 8'd0, 8'd0}, 17'd0, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{'{8'd0, 8'd255, 8'd0}, 17'd16384, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{'{8'd0, 8'd0, 8'd255}, 17'd49152, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{'{8'd255, 8'd255, 8'd0}, 17'd1, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{'{8'd0, 8'd255, 8'd255}, 17'd65535, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{'{8'd255, 8'd0, 8'd255}, 17'd32768, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{'{8'd200, 8'd200, 8'd10}, 17'd20000, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{'{8'd10, 8'd200, 8'd200}, 17'd40000, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{'{8'd200, 8'd10, 8'd10}, 17'd5000, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{'{8'd1, 8'd0, 8'd0}, 17'd0, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{'{8'd255, 8'd254, 8'd0}, 17'd100, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{'{8'd255, 8'd0, 8'd1}, 17'd60000, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{'{8'd100, 8'd50, 8'd51}, 17'd30000, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{'{8'd170, 8'd85, 8'd0}, 17'h10001, 1'b0, '{8'd0, 8'd0, 8'd0}}
  };

  function automatic hls_pkg::pix_req_t rand_req();
    hls_pkg::pix_req_t p;
    hls_pkg::rgb_t c;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    c = 24'($urandom());
    if (kind < 2) begin
      c.green = c.red;
      c.blue = c.red;
    end else if (kind == 2) begin
      c.green = c.red;
    end
    p.red_in = c.red;
    p.green_in = c.green;
    p.blue_in = c.blue;
    case ($urandom_range(0, 5))
      0: p.shift_amt = 17'd0;
      1: p.shift_amt = 17'd65536;
      2: p.shift_amt = 17'($urandom_range(65537, 131071));
      default: p.shift_amt = 17'($urandom_range(0, 65535));
    endcase
    return p;
  endfunction

  initial begin
    hls_pkg::pix_req_t p;
    foreach (dir_tab[k]) begin
      p.red_in = dir_tab[k].rgb.red;
      p.green_in = dir_tab[k].rgb.green;
      p.blue_in = dir_tab[k].rgb.blue;
      p.shift_amt = dir_tab[k].delta;
      reqs.push_back(p);
    end
    repeat (NumRandom) reqs.push_back(rand_req());
  end

  // Request side: bursts of random length with random gaps.
  initial begin
    int unsigned idx, burst, gap;
    in_if.valid <= 1'b0;
    in_if.data <= '0;
    idx = 0;
    burst = $urandom_range(1, 40);
    gap = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (idx < reqs.size()) begin
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        gap--;
      end else begin
        in_if.valid <= 1'b1;
        in_if.data <= reqs[idx];
      end
      @(negedge clk_i);
      if (in_if.valid && in_if.ready) begin
        idx++;
        burst--;
        if (burst == 0) begin
          burst = $urandom_range(1, 40);
          gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      @(posedge clk_i);
    end
    in_if.valid <= 1'b0;
    sending_done = 1'b1;
  end

  // Result side: ready cycles through four stall patterns, or stays low during the hold-off.
  initial begin
    int unsigned cyc;
    cyc = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (hold_off) out_if.ready <= 1'b0;
      else case ((cyc / 64) % 4)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        2: out_if.ready <= ((cyc % 7) < 2);
        default: out_if.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // Long hold-off so the pipeline fills and back-pressures its input.
  initial begin
    int unsigned held;
    wait (n_accepted > 150);
    hold_off = 1'b1;
    held = 0;
    while (held < 300) begin
      @(posedge clk_i);
      held++;
    end
    hold_off = 1'b0;
  end

  always @(negedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      if (n_accepted < dir_tab.size() && dir_tab[n_accepted].known) begin
        known_q.push_back(dir_tab[n_accepted].want);
        is_known.push_back(1'b1);
      end else begin
        is_known.push_back(1'b0);
      end
      shifted_q.push_back(shift_lightness(in_if.data));
      if (in_if.data.red_in == in_if.data.green_in &&
          in_if.data.green_in == in_if.data.blue_in) n_grey++;
      n_accepted++;
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      hls_pkg::pix_res_t want;
      if (shifted_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result %h", out_if.data);
      end else begin
        want = shifted_q.pop_front();
        if (is_known.pop_front()) want = known_q.pop_front();
        if (out_if.data.red_out !== want.red_out ||
            out_if.data.green_out !== want.green_out ||
            out_if.data.blue_out !== want.blue_out) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("result %0d: expected r%0d g%0d b%0d, got r%0d g%0d b%0d",
                     n_results, want.red_out, want.green_out, want.blue_out,
                     out_if.data.red_out, out_if.data.green_out,
                     out_if.data.blue_out);
        end
      end
      n_results++;
    end
  end

  initial begin
    wait (sending_done);
    wait (shifted_q.size() == 0);
    repeat (2 * Latency) @(posedge clk_i);
    if (shifted_q.size() != 0) n_mismatch++;
    $display("%0d pixels sent (%0d grey), %0d results checked, %0d mismatches",
             n_accepted, n_grey, n_results, n_mismatch);
    if (n_mismatch == 0) $display("hsl_lightness_shift regression: pass");
    else $display("hsl_lightness_shift regression: fail");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout waiting for results");
    $display("hsl_lightness_shift regression: fail");
    $finish;
  end
endmodule

### hsl_lightness_shift.f
src/hls_pkg.sv
src/hls_stream_if.sv
src/hls_rdiv.sv
src/hsl_lightness_shift.sv
tb/tb.sv
